>>> hw/rtl/scmr_pkg.sv
// Package for the stream command matcher relay: result type, event codes,
// pattern tables and the prefix-progress transition function.
// No dependencies.
package scmr_pkg;

    typedef logic [7:0] t_pat [16];

    typedef struct packed {
        logic [2:0] event_res;
        logic       relay_on;
        logic       changed;
    } t_res;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_LOST   = 3'd1;
    localparam logic [2:0] EV_CLOSED = 3'd2;
    localparam logic [2:0] EV_ON     = 3'd3;
    localparam logic [2:0] EV_OFF    = 3'd4;

    localparam int LOST_LEN   = 15;
    localparam int CLOSED_LEN = 6;
    localparam int ON_LEN     = 6;
    localparam int OFF_LEN    = 7;

    // "WIFI DISCONNECT"
    localparam t_pat PAT_LOST = '{8'h57, 8'h49, 8'h46, 8'h49, 8'h20, 8'h44, 8'h49, 8'h53,
                                  8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h00};
    // "CLOSED"
    localparam t_pat PAT_CLOSED = '{8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45, 8'h44, 8'h00, 8'h00,
                                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    // "/ledon"
    localparam t_pat PAT_ON = '{8'h2F, 8'h6C, 8'h65, 8'h64, 8'h6F, 8'h6E, 8'h00, 8'h00,
                                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    // "/ledoff"
    localparam t_pat PAT_OFF = '{8'h2F, 8'h6C, 8'h65, 8'h64, 8'h6F, 8'h66, 8'h66, 8'h00,
                                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

    // Matcher automaton step. For every progress value the suffix/prefix checks
    // compare constant pattern bytes only, so each row folds down to a few
    // byte compares against c; the row is then picked by the current progress.
    // Progress at or above the pattern length behaves as zero.
    function automatic logic [3:0] adv(input t_pat p, input int len,
                                       input logic [3:0] prog, input logic [7:0] c);
        logic [3:0] nxt [16];
        logic       ok;
        for (int q = 0; q < 16; q++) begin
            nxt[q] = 4'd0;
            for (int k = 1; k < 16; k++) begin
                if (k <= q + 1 && k <= len && q < len) begin
                    ok = (p[k-1] == c);
                    for (int j = 0; j < 14; j++) begin
                        if (j + 1 < k) begin
                            if (p[j] != p[q-k+1+j]) ok = 1'b0;
                        end
                    end
                    if (ok) nxt[q] = 4'(k);
                end
            end
            if (q >= len) nxt[q] = nxt[0];
        end
        return nxt[prog];
    endfunction

endpackage

>>> hw/rtl/stream_command_matcher_relay_top.sv
// Stream command matcher with relay control: byte-wide matcher for four
// fixed texts and a two-entry output stage. Depends on scmr_pkg.
//
// Usage:
//   Input channel: i_rx_valid / o_rx_ready carry one received byte
//   (i_rx_byte) per transaction.
//   Output channel: o_res_valid / i_res_ready carry one result per input
//   transaction: o_event_res (0 none, 1 link lost, 2 connection closed,
//   3 relay on, 4 relay off), o_relay_on (relay state after the byte) and
//   o_changed (the byte flipped the relay state).
//   The result of a byte is registered at the edge that accepts the byte.
//   Throughput: one byte per cycle while o_rx_ready is high; the matcher
//   state is updated at the accepting edge from four small automaton
//   lookups, so the next byte can follow at once.
//   Stall: a result register plus a skid register sit on the output; one
//   byte is still taken while a result waits, and o_rx_ready drops only
//   when both hold results.
//   Reset (i_rst_n low, synchronous): window count, all progress trackers
//   and the relay state clear (relay off); both output entries empty.
//   The window empties without matching when its count reaches WINDOW-1.
module stream_command_matcher_relay_top #(
    parameter int WINDOW = 200
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_event_res,
    output logic       o_relay_on,
    output logic       o_changed
);
    import scmr_pkg::*;

    localparam int CNT_W = $clog2(WINDOW);
    localparam logic [CNT_W-1:0] FULL_AT = CNT_W'(WINDOW - 1);

    // matcher state
    logic [CNT_W-1:0] r_count, n_count;
    logic [3:0]       r_lost, n_lost;
    logic [2:0]       r_closed, n_closed;
    logic [2:0]       r_on, n_on;
    logic [2:0]       r_off, n_off;
    logic             r_relay, n_relay;

    // output stage
    logic r_out_valid, r_skid_valid;
    t_res r_out, r_skid, n_res;

    logic             accept, take_out;
    logic [CNT_W-1:0] cnt_inc;
    logic [3:0]       lost_adv, closed_adv, on_adv, off_adv;

    assign o_rx_ready  = !r_skid_valid;
    assign accept      = i_rx_valid && o_rx_ready;
    assign take_out    = r_out_valid && i_res_ready;
    assign o_res_valid = r_out_valid;
    assign o_event_res = r_out.event_res;
    assign o_relay_on  = r_out.relay_on;
    assign o_changed   = r_out.changed;

    assign cnt_inc    = r_count + 1'b1;
    assign lost_adv   = adv(PAT_LOST,   LOST_LEN,   r_lost,          i_rx_byte);
    assign closed_adv = adv(PAT_CLOSED, CLOSED_LEN, {1'b0, r_closed}, i_rx_byte);
    assign on_adv     = adv(PAT_ON,     ON_LEN,     {1'b0, r_on},     i_rx_byte);
    assign off_adv    = adv(PAT_OFF,    OFF_LEN,    {1'b0, r_off},    i_rx_byte);

    // Next matcher state and the result of the current byte.
    always_comb begin
        n_count  = cnt_inc;
        n_lost   = lost_adv;
        n_closed = closed_adv[2:0];
        n_on     = on_adv[2:0];
        n_off    = off_adv[2:0];
        n_relay  = r_relay;
        n_res.event_res = EV_NONE;
        n_res.changed   = 1'b0;

        if (cnt_inc >= FULL_AT) begin
            // window full: drop the byte unmatched
            n_count  = '0;
            n_lost   = '0;
            n_closed = '0;
            n_on     = '0;
            n_off    = '0;
        end else begin
            // patterns end in different characters, so at most one completes
            priority if (lost_adv == 4'(LOST_LEN)) begin
                n_res.event_res = EV_LOST;
            end else if (closed_adv == 4'(CLOSED_LEN)) begin
                n_res.event_res = EV_CLOSED;
            end else if (on_adv == 4'(ON_LEN)) begin
                n_res.event_res = EV_ON;
                n_relay         = 1'b1;
                n_res.changed   = !r_relay;
            end else if (off_adv == 4'(OFF_LEN)) begin
                n_res.event_res = EV_OFF;
                n_relay         = 1'b0;
                n_res.changed   = r_relay;
            end else begin
                n_res.event_res = EV_NONE;
            end

            // any completed pattern clears the window
            if (n_res.event_res != EV_NONE) begin
                n_count  = '0;
                n_lost   = '0;
                n_closed = '0;
                n_on     = '0;
                n_off    = '0;
            end
        end
        n_res.relay_on = n_relay;
    end

    // Advance matcher state on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_lost   <= '0;
            r_closed <= '0;
            r_on     <= '0;
            r_off    <= '0;
            r_relay  <= 1'b0;
        end else if (accept) begin
            r_count  <= n_count;
            r_lost   <= n_lost;
            r_closed <= n_closed;
            r_on     <= n_on;
            r_off    <= n_off;
            r_relay  <= n_relay;
        end
    end

    // Output register and skid register: load the result register when it
    // frees up, park a result in the skid register while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take_out) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take_out) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_res;
            end
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

endmodule

>>> test/stream_command_matcher_relay_top_tb.sv
// Self-checking testbench for stream_command_matcher_relay_top: byte stream in,
// one match result out per byte, checked against an in-bench matcher model.
// Depends on scmr_pkg and the top-level RTL.
module stream_command_matcher_relay_top_tb;
    import scmr_pkg::*;

    localparam int WINDOW      = 200;
    localparam int ITEM_TARGET = 1950;
    // Longest run of cycles with no transaction on either channel before giving up.
    localparam int STALL_LIMIT = 3000;
    // Cycles to keep watching the result channel once the last result is in.
    localparam int DRAIN_CYCLES = 8;

    // Command table indexes; a lower index wins when checking for a completed text.
    localparam int CMD_LOST   = 0;
    localparam int CMD_CLOSED = 1;
    localparam int CMD_ON     = 2;
    localparam int CMD_OFF    = 3;

    typedef enum logic [1:0] {RDY_FREE, RDY_COIN, RDY_COMB, RDY_CHOKE} t_rdy_mode;

    // One directed row: a short text sent byte by byte. The final byte's result is
    // typed in; the bytes leading up to it go through the matcher model.
    typedef struct packed {
        logic [127:0] text;
        logic [4:0]   len;
        t_res         last;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [6] = '{
        '{128'h00,            5'd1,  '{EV_NONE,   1'b0, 1'b0}},  // zero byte right after reset
        '{128'hFF,            5'd1,  '{EV_NONE,   1'b0, 1'b0}},  // all-ones byte
        '{"/ledoff",          5'd7,  '{EV_OFF,    1'b0, 1'b0}},  // off while already off
        '{"/ledon",           5'd6,  '{EV_ON,     1'b1, 1'b1}},  // energise
        '{"CLOSED",           5'd6,  '{EV_CLOSED, 1'b1, 1'b0}},  // relay untouched
        '{"WIFI DISCONNECT",  5'd15, '{EV_LOST,   1'b1, 1'b0}}   // relay untouched
    };

    string cmd_text [4] = '{"WIFI DISCONNECT", "CLOSED", "/ledon", "/ledoff"};
    // Characters that build partial commands inside noise.
    string noise_pool = "/ledonfCLOSEDWIFI DISCONNECT";

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_res_valid;
    logic [2:0] o_event_res;
    logic       o_relay_on;
    logic       o_changed;

    stream_command_matcher_relay_top #(
        .WINDOW(WINDOW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .o_res_valid(o_res_valid),
        .i_res_ready(i_res_ready),
        .o_event_res(o_event_res),
        .o_relay_on (o_relay_on),
        .o_changed  (o_changed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Matcher model: window fill, per-command progress and relay state.
    // ------------------------------------------------------------------
    int   win_fill;
    int   cmd_progress [4];
    logic relay_energised;

    t_res pending_results [$];
    int   mismatches;
    int   idle_cycles;
    int   sent_count;
    int   burst_left;

    // Result typed in for the byte now on the input, if any.
    bit   row_typed;
    t_res row_result;

    // Longest k <= progress+1 such that the first k command characters equal the
    // last k-1 matched characters followed by c. Progress at or past the end counts as 0.
    function automatic int next_progress(input string cmd, input int progress,
                                         input logic [7:0] c);
        int  n;
        bit  ok;
        n = cmd.len();
        if (progress >= n) progress = 0;
        for (int k = (progress + 1 > n) ? n : progress + 1; k > 0; k--) begin
            ok = (cmd[k-1] == c);
            for (int j = 0; j + 1 < k; j++) begin
                if (cmd[j] != cmd[progress - k + 1 + j]) ok = 1'b0;
            end
            if (ok) return k;
        end
        return 0;
    endfunction

    function automatic void clear_window();
        win_fill = 0;
        foreach (cmd_progress[p]) cmd_progress[p] = 0;
    endfunction

    // Advance the model by one byte and return the result it must produce.
    function automatic t_res match_byte(input logic [7:0] c);
        t_res r;
        int   hit;
        r   = '0;
        hit = -1;
        win_fill++;
        if (win_fill >= WINDOW - 1) begin
            // Window full: drop the byte unmatched and start over.
            clear_window();
        end else begin
            foreach (cmd_progress[p])
                cmd_progress[p] = next_progress(cmd_text[p], cmd_progress[p], c);
            for (int p = 3; p >= 0; p--) begin
                if (cmd_progress[p] == cmd_text[p].len()) hit = p;
            end
            case (hit)
                CMD_LOST:   r.event_res = EV_LOST;
                CMD_CLOSED: r.event_res = EV_CLOSED;
                CMD_ON: begin
                    r.event_res     = EV_ON;
                    r.changed       = !relay_energised;
                    relay_energised = 1'b1;
                end
                CMD_OFF: begin
                    r.event_res     = EV_OFF;
                    r.changed       = relay_energised;
                    relay_energised = 1'b0;
                end
                default: ;
            endcase
            if (hit >= 0) clear_window();
        end
        r.relay_on = relay_energised;
        return r;
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0) return 8'($urandom);
        return noise_pool[$urandom_range(0, noise_pool.len() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Input side. Entered and left at a falling edge; hold valid and the byte
    // until the transaction goes through. Work in bursts with random gaps.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_res want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        sent_count++;
        row_typed  = typed;
        row_result = want;
        i_rx_byte  <= b;
        i_rx_valid <= 1'b1;
        do @(posedge i_clk); while (!o_rx_ready);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall on a pattern that switches to a random mode after each
    // random-length span, including stretches where the receiver never stalls.
    // ------------------------------------------------------------------
    t_rdy_mode rdy_mode;
    int        rdy_span;
    int        rdy_phase;

    always @(negedge i_clk) begin
        if (rdy_span == 0) begin
            rdy_mode = t_rdy_mode'($urandom_range(0, 3));
            rdy_span = $urandom_range(20, 300);
        end
        rdy_span--;
        rdy_phase++;
        case (rdy_mode)
            RDY_FREE:  i_res_ready <= 1'b1;
            RDY_COIN:  i_res_ready <= ($urandom_range(0, 3) != 0);
            RDY_COMB:  i_res_ready <= ((rdy_phase % 7) < 3);
            RDY_CHOKE: i_res_ready <= ($urandom_range(0, 7) == 0);
            default:   i_res_ready <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest expectation,
    // then record the expectation for any byte taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_res got;
        t_res want;
        t_res model;
        if (i_rst_n) begin
            if (o_res_valid && i_res_ready) begin
                got = {o_event_res, o_relay_on, o_changed};
                if (pending_results.size() == 0) begin
                    $error("result with no byte pending: event_res %0d relay_on %0d changed %0d",
                           o_event_res, o_relay_on, o_changed);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
                        mismatches++;
                    end
                    if (got.relay_on !== want.relay_on) begin
                        $error("relay_on: expected %0d, got %0d", want.relay_on, got.relay_on);
                        mismatches++;
                    end
                    if (got.changed !== want.changed) begin
                        $error("changed: expected %0d, got %0d", want.changed, got.changed);
                        mismatches++;
                    end
                end
            end
            if (i_rx_valid && o_rx_ready) begin
                // Advance the model on every byte, even where the result is typed in.
                model = match_byte(i_rx_byte);
                pending_results.push_back(row_typed ? row_result : model);
            end
            if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // Watchdog: end the run if both channels sit still for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int kind;
        int pick;
        int other;
        int lead;
        string cmd;

        relay_energised = 1'b0;
        clear_window();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes and every command, typing in the final results.
        foreach (DIR_ROWS[r]) begin
            for (int i = 0; i < DIR_ROWS[r].len; i++)
                send_byte(DIR_ROWS[r].text[8*(DIR_ROWS[r].len - 1 - i) +: 8],
                          i == DIR_ROWS[r].len - 1, DIR_ROWS[r].last);
        end

        // Random: mostly whole commands with varied lead-in, plus broken
        // commands, noise runs and commands landing on the window limit.
        while (sent_count < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            pick = $urandom_range(0, 3);
            cmd  = cmd_text[pick];
            if (kind < 4) begin
                // Pad so the last command byte lands one short of, on, or one past
                // the last slot the window still matches.
                lead = (WINDOW - 2) - cmd.len() + $urandom_range(0, 2) - 1 - win_fill;
                if (lead < 0) lead = 0;
                repeat (lead) send_byte(noise_byte(), 1'b0, '0);
                send_text(cmd);
            end else if (kind < 7) begin
                repeat ($urandom_range(60, 250)) send_byte(noise_byte(), 1'b0, '0);
            end else if (kind < 22) begin
                // Truncate a command and break it off with a stray byte.
                send_text(cmd.substr(0, $urandom_range(0, cmd.len() - 2)));
                send_byte(noise_byte(), 1'b0, '0);
            end else begin
                case ($urandom_range(0, 2))
                    0: ;
                    1: repeat ($urandom_range(1, 6)) send_byte(noise_byte(), 1'b0, '0);
                    default: begin
                        // Overlap: a partial command runs straight into a full one.
                        other = $urandom_range(0, 3);
                        send_text(cmd_text[other].substr(0,
                                  $urandom_range(0, cmd_text[other].len() - 2)));
                    end
                endcase
                send_text(cmd);
            end
        end
        i_rx_valid <= 1'b0;

        // Drain: wait for every expected result, then keep watching the result channel.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/scmr_pkg.sv
hw/rtl/stream_command_matcher_relay_top.sv
test/stream_command_matcher_relay_top_tb.sv
